// ----- rtl/touch_tap_double_tap_detector_top_defines.svh -----
// Assertion macros used by the checker file.
`ifndef TOUCH_TAP_DOUBLE_TAP_DETECTOR_TOP_DEFINES_SVH
`define TOUCH_TAP_DOUBLE_TAP_DETECTOR_TOP_DEFINES_SVH

// cond at this edge implies cons at the same edge
`define TTDTD_ASSERT_NOW(label, cond, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (cons)) \
        else $error(msg);

// cond at this edge implies cons at the next edge
`define TTDTD_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ttdtd_pkg.sv -----
package ttdtd_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int TIME_BITS_DEF  = 32;

    // fixed register widths
    localparam int DUR_W  = 16;
    localparam int MOVE_W = 12;
    localparam int CFG_W  = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [DUR_W-1:0]  TAP_MAX_DURATION_RST = 16'd250;
    localparam logic [MOVE_W-1:0] TAP_MAX_MOVEMENT_RST = 12'd20;
    localparam logic [DUR_W-1:0]  DOUBLE_TAP_WINDOW_RST = 16'd400;

    typedef enum logic [1:0] {
        CMD_PRESS   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_X       = 2'd2,
        CMD_Y       = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAP_MAX_DURATION  = 2'd0,
        CFG_TAP_MAX_MOVEMENT  = 2'd1,
        CFG_DOUBLE_TAP_WINDOW = 2'd2
    } cfg_idx_t;

    // per-axis control from the event decoder
    typedef struct packed {
        logic clear;   // drop start point and deviation
        logic sample;  // a coordinate for this axis arrived
    } axis_ctrl_t;

endpackage

// ----- rtl/touch_tap_double_tap_detector_top.sv -----
// Channel   Ports                                         Transaction
// -------   --------------------------------------------  ---------------------------
// input     s_valid s_ready s_command s_coord_value       one touch event
//           s_timestamp_ms
// result    m_valid m_ready m_tap_seen m_double_tap        one flag pair per event
// config    cfg_wr_en cfg_addr cfg_wdata                  register write, no handshake
//
// One event per cycle unless stalled: the event is decoded against the contact state
// in the cycle it is accepted, and its flags land in the result register at that edge.
// A waiting result does not block input unless it is stalled: s_ready drops only
// while m_valid is high and m_ready is low.
// Synchronous active-low reset clears the contact and pending-tap state and the result
// valid flag, and loads the register defaults (250 ms, 20, 400 ms).
module touch_tap_double_tap_detector_top
    import ttdtd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    // touch events
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_command,
    input  logic [COORD_BITS-1:0] s_coord_value,
    input  logic [TIME_BITS-1:0]  s_timestamp_ms,
    // results
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_tap_seen,
    output logic                  m_double_tap
);

    // movement compare width covers both the deviation and the register
    localparam int MOV_CMP_W = (COORD_BITS > MOVE_W) ? COORD_BITS : MOVE_W;

    // configuration registers
    logic [DUR_W-1:0]  tap_max_duration_reg;
    logic [MOVE_W-1:0] tap_max_movement_reg;
    logic [DUR_W-1:0]  double_tap_window_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_max_duration_reg  <= TAP_MAX_DURATION_RST;
            tap_max_movement_reg  <= TAP_MAX_MOVEMENT_RST;
            double_tap_window_reg <= DOUBLE_TAP_WINDOW_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_TAP_MAX_DURATION:  tap_max_duration_reg  <= cfg_wdata[DUR_W-1:0];
                CFG_TAP_MAX_MOVEMENT:  tap_max_movement_reg  <= cfg_wdata[MOVE_W-1:0];
                CFG_DOUBLE_TAP_WINDOW: double_tap_window_reg <= cfg_wdata[DUR_W-1:0];
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    // handshake: result register with stall-only backpressure
    logic m_valid_reg, m_valid_next;
    logic m_tap_seen_reg, m_tap_seen_next;
    logic m_double_tap_reg, m_double_tap_next;
    logic accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // contact state
    logic                 contact_open_reg, contact_open_next;
    logic [TIME_BITS-1:0] press_time_reg, press_time_next;
    logic [TIME_BITS-1:0] last_tap_time_reg, last_tap_time_next;
    logic                 tap_waiting_reg, tap_waiting_next;

    axis_ctrl_t            x_ctrl, y_ctrl;
    logic                  have_x, have_y;
    logic [COORD_BITS-1:0] dev_x, dev_y;

    // release classification, all modulo 2^TIME_BITS
    logic [TIME_BITS-1:0] dur;
    logic [TIME_BITS-1:0] gap;
    logic                 is_tap;
    logic                 in_window;

    assign dur = s_timestamp_ms - press_time_reg;
    assign gap = s_timestamp_ms - last_tap_time_reg;
    assign is_tap = (dur <= TIME_BITS'(tap_max_duration_reg))
                 && (MOV_CMP_W'(dev_x) <= MOV_CMP_W'(tap_max_movement_reg))
                 && (MOV_CMP_W'(dev_y) <= MOV_CMP_W'(tap_max_movement_reg));
    assign in_window = tap_waiting_reg && (gap <= TIME_BITS'(double_tap_window_reg));

    always_comb begin
        contact_open_next  = contact_open_reg;
        press_time_next    = press_time_reg;
        last_tap_time_next = last_tap_time_reg;
        tap_waiting_next   = tap_waiting_reg;
        x_ctrl             = '0;
        y_ctrl             = '0;
        m_valid_next       = m_valid_reg && !m_ready;
        m_tap_seen_next    = m_tap_seen_reg;
        m_double_tap_next  = m_double_tap_reg;

        if (accept) begin
            m_valid_next      = 1'b1;
            m_tap_seen_next   = 1'b0;
            m_double_tap_next = 1'b0;
            unique case (cmd_t'(s_command))
                CMD_PRESS: begin
                    // a press while open just restarts the contact
                    contact_open_next = 1'b1;
                    press_time_next   = s_timestamp_ms;
                    x_ctrl.clear      = 1'b1;
                    y_ctrl.clear      = 1'b1;
                end
                CMD_RELEASE: begin
                    if (contact_open_reg) begin
                        contact_open_next = 1'b0;
                        x_ctrl.clear      = 1'b1;
                        y_ctrl.clear      = 1'b1;
                        if (!have_x || !have_y || !is_tap) begin
                            tap_waiting_next = 1'b0;
                        end else if (in_window) begin
                            tap_waiting_next  = 1'b0;
                            m_double_tap_next = 1'b1;
                        end else begin
                            tap_waiting_next   = 1'b1;
                            last_tap_time_next = s_timestamp_ms;
                            m_tap_seen_next    = 1'b1;
                        end
                    end
                end
                CMD_X: x_ctrl.sample = contact_open_reg;
                CMD_Y: y_ctrl.sample = contact_open_reg;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            contact_open_reg  <= 1'b0;
            press_time_reg    <= '0;
            last_tap_time_reg <= '0;
            tap_waiting_reg   <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            contact_open_reg  <= contact_open_next;
            press_time_reg    <= press_time_next;
            last_tap_time_reg <= last_tap_time_next;
            tap_waiting_reg   <= tap_waiting_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    // result payload needs no reset
    always_ff @(posedge aclk) begin
        m_tap_seen_reg   <= m_tap_seen_next;
        m_double_tap_reg <= m_double_tap_next;
    end

    ttdtd_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (x_ctrl),
        .coord      (s_coord_value),
        .have_start (have_x),
        .max_dev    (dev_x)
    );

    ttdtd_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (y_ctrl),
        .coord      (s_coord_value),
        .have_start (have_y),
        .max_dev    (dev_y)
    );

    assign m_valid      = m_valid_reg;
    assign m_tap_seen   = m_tap_seen_reg;
    assign m_double_tap = m_double_tap_reg;

endmodule

// ----- rtl/ttdtd_axis.sv -----
module ttdtd_axis
    import ttdtd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  axis_ctrl_t            ctrl,
    input  logic [COORD_BITS-1:0] coord,
    output logic                  have_start,
    output logic [COORD_BITS-1:0] max_dev
);

    logic                  have_start_reg, have_start_next;
    logic [COORD_BITS-1:0] start_reg, start_next;
    logic [COORD_BITS-1:0] max_dev_reg, max_dev_next;
    logic [COORD_BITS-1:0] start_eff;
    logic [COORD_BITS-1:0] dev;

    // first sample of a contact becomes the start point
    assign start_eff = have_start_reg ? start_reg : coord;
    assign dev = (coord >= start_eff) ? (coord - start_eff) : (start_eff - coord);

    always_comb begin
        have_start_next = have_start_reg;
        start_next      = start_reg;
        max_dev_next    = max_dev_reg;
        if (ctrl.clear) begin
            have_start_next = 1'b0;
            start_next      = '0;
            max_dev_next    = '0;
        end else if (ctrl.sample) begin
            have_start_next = 1'b1;
            start_next      = start_eff;
            if (dev > max_dev_reg) begin
                max_dev_next = dev;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_start_reg <= 1'b0;
            start_reg      <= '0;
            max_dev_reg    <= '0;
        end else begin
            have_start_reg <= have_start_next;
            start_reg      <= start_next;
            max_dev_reg    <= max_dev_next;
        end
    end

    assign have_start = have_start_reg;
    assign max_dev    = max_dev_reg;

endmodule

// ----- rtl/ttdtd_checker.sv -----
`include "touch_tap_double_tap_detector_top_defines.svh"

module ttdtd_checker
    import ttdtd_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [1:0] s_command,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_tap_seen,
    input logic       m_double_tap
);

    // stalled result holds
    `TTDTD_ASSERT_NEXT(a_result_hold, m_valid && !m_ready,
        m_valid && $stable(m_tap_seen) && $stable(m_double_tap), "stalled result changed")

    // input is blocked only by a stalled result
    `TTDTD_ASSERT_NOW(a_ready_stall, !s_ready, m_valid && !m_ready, "s_ready low without stall")

    // only a release can raise a flag
    `TTDTD_ASSERT_NEXT(a_non_release_zero, s_valid && s_ready && s_command != CMD_RELEASE,
        m_valid && !m_tap_seen && !m_double_tap, "flag raised on non-release event")

    // a release is a single or a double tap, never both
    `TTDTD_ASSERT_NOW(a_flags_exclusive, m_valid, !(m_tap_seen && m_double_tap),
        "tap and double tap both set")

endmodule

bind touch_tap_double_tap_detector_top ttdtd_checker u_ttdtd_checker (.*);

// ----- bench/tb_touch_tap_double_tap_detector_top.sv -----
module tb_touch_tap_double_tap_detector_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ttdtd_pkg::*;

    // Watchdog limit, far beyond what a clean run needs.
    localparam int unsigned CYCLE_LIMIT = 200000;
    // Percentage of cycles in which a side holds back.
    localparam int unsigned IDLE_PCT = 20;
    localparam int unsigned COORD_MAX = (1 << COORD_BITS_DEF) - 1;

    typedef logic [COORD_BITS_DEF-1:0] coord_t;
    typedef logic [TIME_BITS_DEF-1:0]  ms_t;

    // One touch event as it crosses the input channel.
    typedef struct {
        cmd_t   cmd;
        coord_t coord;
        ms_t    ms;
    } touch_ev_t;

    // Flag pair that every event produces.
    typedef struct packed {
        logic tap;
        logic dbl;
    } tap_flags_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_command = '0;
    coord_t               s_coord_value = '0;
    ms_t                  s_timestamp_ms = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_tap_seen;
    logic                 m_double_tap;

    // Events waiting for the driver, and flag pairs waiting for the DUT.
    touch_ev_t  touch_backlog[$];
    tap_flags_t flags_due[$];

    int unsigned mismatch_count = 0;
    int unsigned queued_total = 0;
    int unsigned cycle_count = 0;
    // Set during one traffic phase: neither side idles.
    bit          steady = 1'b0;
    // Running uptime used when building gestures.
    ms_t         now_ms = '0;

    // Shadow of the three limit registers.
    logic [DUR_W-1:0]  lim_dur = TAP_MAX_DURATION_RST;
    logic [MOVE_W-1:0] lim_move = TAP_MAX_MOVEMENT_RST;
    logic [DUR_W-1:0]  lim_win = DOUBLE_TAP_WINDOW_RST;

    // Shadow of the contact tracker and of the pending tap.
    bit     contact_open = 1'b0;
    bit     have_x = 1'b0;
    bit     have_y = 1'b0;
    bit     tap_armed = 1'b0;
    coord_t start_x = '0;
    coord_t start_y = '0;
    coord_t dev_x = '0;
    coord_t dev_y = '0;
    ms_t    press_ms = '0;
    ms_t    last_tap_ms = '0;

    touch_tap_double_tap_detector_top i_dut (.*);

    always #5ns aclk = ~aclk;

    // Cycle watchdog: a hang or a lost transaction ends up here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic coord_t coord_dist(input coord_t a, input coord_t b);
        return (a >= b) ? coord_t'(a - b) : coord_t'(b - a);
    endfunction

    // Drop the start point and the deviations of the open contact.
    function automatic void forget_contact();
        have_x = 1'b0;
        have_y = 1'b0;
        start_x = '0;
        start_y = '0;
        dev_x = '0;
        dev_y = '0;
    endfunction

    // Advance the shadow state by one event and return the flags it yields.
    function automatic tap_flags_t classify_event(input touch_ev_t ev);
        tap_flags_t f;
        ms_t        held;
        coord_t     d;
        f = '0;
        case (ev.cmd)
            CMD_PRESS: begin
                // a press on an open contact simply restarts it
                contact_open = 1'b1;
                forget_contact();
                press_ms = ev.ms;
            end
            CMD_RELEASE: begin
                if (contact_open) begin
                    if (!have_x || !have_y) begin
                        tap_armed = 1'b0;
                    end else begin
                        held = ev.ms - press_ms;
                        if (held > ms_t'(lim_dur) || dev_x > lim_move || dev_y > lim_move) begin
                            tap_armed = 1'b0;
                        end else if (tap_armed && ms_t'(ev.ms - last_tap_ms) <= ms_t'(lim_win)) begin
                            tap_armed = 1'b0;
                            f.dbl = 1'b1;
                        end else begin
                            tap_armed = 1'b1;
                            last_tap_ms = ev.ms;
                            f.tap = 1'b1;
                        end
                    end
                    contact_open = 1'b0;
                    forget_contact();
                end
            end
            CMD_X: begin
                if (contact_open) begin
                    if (!have_x) begin
                        have_x = 1'b1;
                        start_x = ev.coord;
                    end
                    d = coord_dist(ev.coord, start_x);
                    if (d > dev_x) dev_x = d;
                end
            end
            default: begin
                if (contact_open) begin
                    if (!have_y) begin
                        have_y = 1'b1;
                        start_y = ev.coord;
                    end
                    d = coord_dist(ev.coord, start_y);
                    if (d > dev_y) dev_y = d;
                end
            end
        endcase
        return f;
    endfunction

    // Driver: presents the backlog one transaction at a time. A new event is
    // only loaded when the slot is empty or the current one is taken.
    always @(posedge aclk) begin : drive
        touch_ev_t ev;
        if (aresetn && (!s_valid || s_ready)) begin
            if (touch_backlog.size() != 0 && (steady || $urandom_range(99, 0) >= IDLE_PCT)) begin
                ev = touch_backlog.pop_front();
                s_valid <= 1'b1;
                s_command <= ev.cmd;
                s_coord_value <= ev.coord;
                s_timestamp_ms <= ev.ms;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks the result transaction first, then predicts for the
    // input transaction of the same edge, so the queue order never races.
    always @(posedge aclk) begin : watch
        touch_ev_t  ev;
        tap_flags_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (flags_due.size() == 0) begin
                    $error("result with no event outstanding: tap_seen=%0b double_tap=%0b",
                           m_tap_seen, m_double_tap);
                    mismatch_count++;
                end else begin
                    want = flags_due.pop_front();
                    if (m_tap_seen !== want.tap) begin
                        $error("tap_seen: expected %0b, got %0b", want.tap, m_tap_seen);
                        mismatch_count++;
                    end
                    if (m_double_tap !== want.dbl) begin
                        $error("double_tap: expected %0b, got %0b", want.dbl, m_double_tap);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                ev.cmd = cmd_t'(s_command);
                ev.coord = s_coord_value;
                ev.ms = s_timestamp_ms;
                flags_due.push_back(classify_event(ev));
            end
        end
        m_ready <= steady || ($urandom_range(99, 0) >= IDLE_PCT);
    end

    task automatic push_event(input cmd_t c, input coord_t v, input ms_t t);
        touch_ev_t ev;
        ev.cmd = c;
        ev.coord = v;
        ev.ms = t;
        touch_backlog.push_back(ev);
        queued_total++;
    endtask

    // A coordinate at most reach away from c, kept inside the axis.
    function automatic coord_t coord_near(input coord_t c, input int unsigned reach);
        int unsigned d;
        int unsigned base;
        base = 32'(c);
        d = $urandom_range(reach, 0);
        if (d > COORD_MAX) d = COORD_MAX;
        if ($urandom_range(1, 0) == 1 && base + d <= COORD_MAX) return coord_t'(base + d);
        if (base >= d) return coord_t'(base - d);
        if (base + d <= COORD_MAX) return coord_t'(base + d);
        return (base >= COORD_MAX / 2) ? coord_t'(0) : coord_t'(COORD_MAX);
    endfunction

    // One press..release gesture. Hold time, movement and the gap to the
    // previous release are drawn around the current limits so both sides of
    // every compare show up.
    task automatic add_gesture();
        int unsigned dl, mv, win, gap, held, reach, shape;
        coord_t      sx, sy;
        ms_t         t0;
        dl = 32'(lim_dur);
        mv = 32'(lim_move);
        win = 32'(lim_win);
        gap = ($urandom_range(4, 0) == 0) ? $urandom_range(win + win / 2 + 4, 0)
                                          : $urandom_range(win / 2 + 2, 0);
        held = ($urandom_range(9, 0) < 7) ? $urandom_range(dl / 2 + 1, 0)
                                          : $urandom_range(dl + dl / 8 + 3, 0);
        t0 = now_ms + ms_t'(gap);
        push_event(CMD_PRESS, coord_t'($urandom), t0);
        // now and then a second press restarts the contact
        if ($urandom_range(9, 0) == 0) begin
            t0 = t0 + ms_t'($urandom_range(50, 0));
            push_event(CMD_PRESS, coord_t'($urandom), t0);
        end
        // shape 0: no X at all, shape 1: no Y at all
        shape = $urandom_range(11, 0);
        reach = ($urandom_range(6, 0) == 0) ? mv + 40 : mv + 2;
        sx = coord_t'($urandom);
        sy = coord_t'($urandom);
        if (shape != 0) push_event(CMD_X, sx, t0);
        if (shape != 1) push_event(CMD_Y, sy, t0);
        repeat ($urandom_range(4, 0)) begin
            if (shape == 0 || (shape != 1 && $urandom_range(1, 0) == 1))
                push_event(CMD_Y, coord_near(sy, reach), t0);
            else
                push_event(CMD_X, coord_near(sx, reach), t0);
        end
        now_ms = t0 + ms_t'(held);
        push_event(CMD_RELEASE, coord_t'($urandom), now_ms);
    endtask

    // Mostly well-formed gestures, with loose events mixed in.
    task automatic add_traffic(input int unsigned n);
        int unsigned mark;
        mark = queued_total;
        while (queued_total - mark < n) begin
            if ($urandom_range(99, 0) < 15)
                push_event(cmd_t'($urandom_range(3, 0)), coord_t'($urandom),
                           ($urandom_range(1, 0) == 1) ? ms_t'($urandom)
                                                       : now_ms + ms_t'($urandom_range(500, 0)));
            else
                add_gesture();
        end
    endtask

    // Wait until every event is taken and every flag pair is back, plus the
    // DUT's pipeline depth and some margin.
    task automatic drain();
        while (touch_backlog.size() != 0 || s_valid || flags_due.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val[CFG_W-1:0];
        case (idx)
            CFG_TAP_MAX_DURATION: lim_dur = val[DUR_W-1:0];
            CFG_TAP_MAX_MOVEMENT: lim_move = val[MOVE_W-1:0];
            default:              lim_win = val[DUR_W-1:0];
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_limits(input int unsigned dur, input int unsigned move,
                                input int unsigned win);
        write_reg(CFG_TAP_MAX_DURATION, dur);
        write_reg(CFG_TAP_MAX_MOVEMENT, move);
        write_reg(CFG_DOUBLE_TAP_WINDOW, win);
    endtask

    initial begin : stimulus
        int unsigned p;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed, under the reset limits (250 ms, 20, 400 ms).
        // Release and coordinates with no contact open: ignored.
        push_event(CMD_RELEASE, coord_t'(0), ms_t'(0));
        push_event(CMD_X, coord_t'(COORD_MAX), ms_t'(0));
        push_event(CMD_Y, coord_t'(0), ms_t'(0));
        // Deviation and hold time exactly at the limits: a tap.
        push_event(CMD_PRESS, coord_t'(0), ms_t'(100));
        push_event(CMD_X, coord_t'(COORD_MAX), ms_t'(100));
        push_event(CMD_Y, coord_t'(0), ms_t'(100));
        push_event(CMD_X, coord_t'(COORD_MAX - 20), ms_t'(120));
        push_event(CMD_Y, coord_t'(20), ms_t'(120));
        push_event(CMD_RELEASE, coord_t'(0), ms_t'(350));
        // Press while a contact is open restarts it; second tap exactly
        // at the window edge completes a double tap.
        push_event(CMD_PRESS, coord_t'(0), ms_t'(400));
        push_event(CMD_PRESS, coord_t'(0), ms_t'(500));
        push_event(CMD_X, coord_t'(0), ms_t'(500));
        push_event(CMD_Y, coord_t'(COORD_MAX), ms_t'(500));
        push_event(CMD_RELEASE, coord_t'(0), ms_t'(750));
        // Across the time wrap, one step too much movement: not a tap.
        push_event(CMD_PRESS, coord_t'(0), ms_t'(32'hFFFF_FFF0));
        push_event(CMD_X, coord_t'(100), ms_t'(32'hFFFF_FFF0));
        push_event(CMD_Y, coord_t'(100), ms_t'(32'hFFFF_FFF0));
        push_event(CMD_X, coord_t'(121), ms_t'(32'hFFFF_FFF8));
        push_event(CMD_RELEASE, coord_t'(0), ms_t'(32'h0000_0050));
        // Across the wrap again, clean: a fresh single tap.
        push_event(CMD_PRESS, coord_t'(0), ms_t'(32'hFFFF_FFFF));
        push_event(CMD_X, coord_t'(5), ms_t'(32'hFFFF_FFFF));
        push_event(CMD_Y, coord_t'(7), ms_t'(32'hFFFF_FFFF));
        push_event(CMD_RELEASE, coord_t'(0), ms_t'(32'h0000_0020));
        // Release without a Y start point drops the pending tap.
        push_event(CMD_PRESS, coord_t'(0), ms_t'(32'h0000_0030));
        push_event(CMD_X, coord_t'(1), ms_t'(32'h0000_0030));
        push_event(CMD_RELEASE, coord_t'(0), ms_t'(32'h0000_0040));
        drain();

        // All limits at zero, then all at their maximum.
        now_ms = ms_t'($urandom);
        write_limits(0, 0, 0);
        add_traffic(150);
        drain();
        write_limits(65535, COORD_MAX, 65535);
        add_traffic(150);
        drain();

        // Random limits, mostly in the range where gestures straddle them.
        for (p = 0; p < 7; p++) begin
            write_limits(($urandom_range(3, 0) == 0) ? $urandom_range(65535, 0)
                                                     : $urandom_range(600, 0),
                         ($urandom_range(3, 0) == 0) ? $urandom_range(COORD_MAX, 0)
                                                     : $urandom_range(60, 0),
                         ($urandom_range(3, 0) == 0) ? $urandom_range(65535, 0)
                                                     : $urandom_range(800, 0));
            // one phase runs back to back with no idle cycles on either side
            steady = (p == 3);
            add_traffic(220);
            drain();
        end

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
